// File: hw/rtl/sorted_key_table_core_macros.svh
// assertion macros used by the sorted key table controller
`ifndef SORTED_KEY_TABLE_CORE_MACROS_SVH
`define SORTED_KEY_TABLE_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SKT_ASSERT_IMP(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define SKT_ASSERT_NXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: hw/rtl/skt_pkg.sv
// types and codes shared by the sorted key table controller and datapath
package skt_pkg;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_APPEND = 3'd1,
      OP_EXISTS = 3'd2,
      OP_READ   = 3'd3,
      OP_REMOVE = 3'd4,
      OP_FIND   = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      RA_LAST,
      RA_MID,
      RA_LO,
      RA_POS,
      RA_PTR_DN,
      RA_PTR_UP,
      RA_PTR,
      RA_IDX
   } ra_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SHIFT,
      WR_NEW,
      WR_APPEND
   } wr_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_LAST,
      ACT_MID,
      ACT_LO,
      ACT_EX_CHK,
      ACT_SH_SET,
      ACT_DEC,
      ACT_INC,
      ACT_SET_IDX,
      ACT_H_CHK,
      ACT_RD_OUT,
      ACT_FIN
   } act_type;

   typedef struct packed {
      act_type act;
      ra_type  ra;
      wr_type  wr;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   count_zero;
      logic   count_one;
      logic   full;
      logic   gt;
      logic   adjacent;
      logic   pos_lt_count;
      logic   idx_ok;
      logic   ptr_gt_pos;
      logic   rm_more;
      logic   fd_more;
      logic   hmatch;
   } stat_type;

endpackage

// File: hw/rtl/sorted_key_table_core.sv
// top level of the sorted key table core
// A table of up to DEPTH key/handle entries held in two rams.
// Request: drive req_* with start high; the request is taken at a clock edge
// where start is high and busy is low. busy stays high until the response.
// Response: rsp_valid pulses for one cycle with rsp_* valid; the receiver
// cannot hold it off and rsp_* may change afterwards.
// One request at a time. Steps per request, after the request edge:
//   append, clear, bad index, unused opcode: dispatch, then finish
//   read: one ram read; remove: move each entry after the index down one
//   find: read entries from the first until the handle matches or none is left
//   exists / sorted insert with two or more entries: check the last entry, then
//   halve the range with midpoint probes; less work on an empty table or a key
//   above the last entry; insert into a full table moves nothing, else each
//   entry above the position moves up one. Each ram access goes through the
//   registered read; entries move one at a time through the single write port.
// A new request may be started in the cycle of the response strobe.
// Reset empties the table at once (count to zero); no clearing pass.
module sorted_key_table_core #(
   parameter int DEPTH       = 64,
   parameter int KEY_BITS    = 32,
   parameter int HANDLE_BITS = 16,
   localparam int CNT_W = ($clog2(DEPTH + 1) > 7) ? $clog2(DEPTH + 1) : 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_opcode,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [HANDLE_BITS-1:0] req_handle,
   input  logic [5:0]             req_index,
   output logic                   rsp_valid,
   output logic                   rsp_ok,
   output logic                   rsp_found,
   output logic [CNT_W-1:0]       rsp_position,
   output logic [KEY_BITS-1:0]    rsp_key_out,
   output logic [HANDLE_BITS-1:0] rsp_handle_out,
   output logic [CNT_W-1:0]       rsp_entry_count
);
   import skt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   skt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   skt_datapath #(
      .DEPTH       (DEPTH),
      .KEY_BITS    (KEY_BITS),
      .HANDLE_BITS (HANDLE_BITS),
      .CNT_W       (CNT_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_handle      (req_handle),
      .req_index       (req_index),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ok          (rsp_ok),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_key_out     (rsp_key_out),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_entry_count (rsp_entry_count)
   );
endmodule

// File: hw/rtl/skt_ram.sv
// generic single write port, single read port ram with registered read
module skt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: hw/rtl/skt_datapath.sv
// datapath of the sorted key table: request registers, bounds, pointer and stores
module skt_datapath #(
   parameter int DEPTH       = 64,
   parameter int KEY_BITS    = 32,
   parameter int HANDLE_BITS = 16,
   parameter int CNT_W       = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             req_opcode,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [HANDLE_BITS-1:0] req_handle,
   input  logic [5:0]             req_index,
   input  skt_pkg::cmd_type       cmd,
   output skt_pkg::stat_type      stat,
   output logic                   rsp_ok,
   output logic                   rsp_found,
   output logic [CNT_W-1:0]       rsp_position,
   output logic [KEY_BITS-1:0]    rsp_key_out,
   output logic [HANDLE_BITS-1:0] rsp_handle_out,
   output logic [CNT_W-1:0]       rsp_entry_count
);
   import skt_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   op_type                 op_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [HANDLE_BITS-1:0] hnd_ff;
   logic [5:0]             idx_ff;
   logic [CNT_W-1:0]       count_ff, lo_ff, hi_ff, ptr_ff, pos_ff;
   logic                   ok_ff, found_ff;
   logic [KEY_BITS-1:0]    kout_ff;
   logic [HANDLE_BITS-1:0] hout_ff;

   logic [KEY_BITS-1:0]    rd_key;
   logic [HANDLE_BITS-1:0] rd_hnd;
   logic [CNT_W-1:0]       idx_ext, mid, ra_full, wa_full;
   logic [CNT_W:0]         mid_sum;
   logic [AW-1:0]          raddr, waddr;
   logic [KEY_BITS-1:0]    wkey;
   logic [HANDLE_BITS-1:0] whnd;
   logic                   we;

   assign idx_ext = {{(CNT_W-6){1'b0}}, idx_ff};
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_W:1];

   always_comb begin
      case (cmd.ra)
         RA_LAST:   ra_full = count_ff - ONE_C;
         RA_MID:    ra_full = mid;
         RA_LO:     ra_full = lo_ff;
         RA_POS:    ra_full = pos_ff;
         RA_PTR_DN: ra_full = ptr_ff - ONE_C;
         RA_PTR_UP: ra_full = ptr_ff + ONE_C;
         RA_PTR:    ra_full = ptr_ff;
         RA_IDX:    ra_full = idx_ext;
         default:   ra_full = ptr_ff;
      endcase
   end
   assign raddr = ra_full[AW-1:0];

   always_comb begin
      we      = 1'b1;
      wa_full = ptr_ff;
      wkey    = rd_key;
      whnd    = rd_hnd;
      case (cmd.wr)
         WR_SHIFT: begin
            wa_full = ptr_ff;
         end
         WR_NEW: begin
            wa_full = pos_ff;
            wkey    = key_ff;
            whnd    = hnd_ff;
         end
         WR_APPEND: begin
            wa_full = count_ff;
            wkey    = key_ff;
            whnd    = hnd_ff;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end
   assign waddr = wa_full[AW-1:0];

   skt_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wkey),
      .rd_addr (raddr),
      .rd_data (rd_key)
   );

   skt_ram #(.WIDTH(HANDLE_BITS), .DEPTH(DEPTH)) u_handle_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (whnd),
      .rd_addr (raddr),
      .rd_data (rd_hnd)
   );

   always_comb begin
      stat.op           = op_ff;
      stat.count_zero   = (count_ff == '0);
      stat.count_one    = (count_ff == ONE_C);
      stat.full         = (count_ff >= DEPTH_C);
      stat.gt           = (key_ff > rd_key);
      stat.adjacent     = (hi_ff == lo_ff + ONE_C);
      stat.pos_lt_count = (pos_ff < count_ff);
      stat.idx_ok       = (idx_ext < count_ff);
      stat.ptr_gt_pos   = (ptr_ff > pos_ff);
      stat.rm_more      = (ptr_ff + ONE_C < count_ff);
      stat.fd_more      = (ptr_ff < count_ff);
      stat.hmatch       = (hnd_ff == rd_hnd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         case (cmd.act)
            ACT_LOAD: begin
               op_ff    <= op_type'(req_opcode);
               key_ff   <= req_key;
               hnd_ff   <= req_handle;
               idx_ff   <= req_index;
               ok_ff    <= 1'b0;
               found_ff <= 1'b0;
               kout_ff  <= '0;
               hout_ff  <= '0;
               ptr_ff   <= '0;
               pos_ff   <= (req_opcode inside {OP_APPEND, OP_FIND}) ? count_ff : '0;
            end
            ACT_LAST: begin
               if (stat.gt) begin
                  pos_ff <= count_ff;
               end else begin
                  lo_ff  <= '0;
                  hi_ff  <= count_ff - ONE_C;
                  pos_ff <= '0;
               end
            end
            ACT_MID: begin
               if (stat.gt) begin
                  lo_ff <= mid;
               end else begin
                  hi_ff <= mid;
               end
            end
            ACT_LO: begin
               pos_ff <= stat.gt ? hi_ff : lo_ff;
            end
            ACT_EX_CHK: begin
               found_ff <= (key_ff == rd_key);
            end
            ACT_SH_SET: begin
               ptr_ff <= count_ff;
            end
            ACT_DEC: begin
               ptr_ff <= ptr_ff - ONE_C;
            end
            ACT_INC: begin
               ptr_ff <= ptr_ff + ONE_C;
            end
            ACT_SET_IDX: begin
               ptr_ff <= idx_ext;
            end
            ACT_H_CHK: begin
               if (stat.hmatch) begin
                  pos_ff   <= ptr_ff;
                  found_ff <= 1'b1;
               end else begin
                  ptr_ff <= ptr_ff + ONE_C;
               end
            end
            ACT_RD_OUT: begin
               kout_ff  <= rd_key;
               hout_ff  <= rd_hnd;
               found_ff <= 1'b1;
            end
            ACT_FIN: begin
               case (op_ff)
                  OP_INSERT, OP_APPEND: begin
                     if (!stat.full) begin
                        ok_ff    <= 1'b1;
                        count_ff <= count_ff + ONE_C;
                     end
                  end
                  OP_EXISTS, OP_FIND: begin
                     ok_ff <= 1'b1;
                  end
                  OP_READ: begin
                     pos_ff <= idx_ext;
                     ok_ff  <= stat.idx_ok;
                  end
                  OP_REMOVE: begin
                     pos_ff <= idx_ext;
                     if (stat.idx_ok) begin
                        ok_ff    <= 1'b1;
                        count_ff <= count_ff - ONE_C;
                     end
                  end
                  OP_CLEAR: begin
                     ok_ff    <= 1'b1;
                     count_ff <= '0;
                     pos_ff   <= '0;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_ok          = ok_ff;
   assign rsp_found       = found_ff;
   assign rsp_position    = pos_ff;
   assign rsp_key_out     = kout_ff;
   assign rsp_handle_out  = hout_ff;
   assign rsp_entry_count = count_ff;
endmodule

// File: hw/rtl/skt_controller.sv
// controller state machine of the sorted key table
module skt_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output skt_pkg::cmd_type  cmd,
   input  skt_pkg::stat_type stat
);
   import skt_pkg::*;

   `include "sorted_key_table_core_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_LAST_CHK,
      S_MID_TEST,
      S_MID_CHK,
      S_LO_CHK,
      S_POS_DONE,
      S_EX_CHK,
      S_SH_TEST,
      S_SH_WR,
      S_RM_TEST,
      S_RM_WR,
      S_FD_TEST,
      S_FD_CHK,
      S_RD_CHK,
      S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.act  = ACT_NONE;
      cmd.ra   = RA_PTR;
      cmd.wr   = WR_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.act  = ACT_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.op)
               OP_INSERT, OP_EXISTS: begin
                  if (stat.count_zero) begin
                     state_in = S_POS_DONE;
                  end else begin
                     cmd.ra   = RA_LAST;
                     state_in = S_LAST_CHK;
                  end
               end
               OP_APPEND: begin
                  if (!stat.full) begin
                     cmd.wr = WR_APPEND;
                  end
                  state_in = S_FIN;
               end
               OP_READ: begin
                  if (stat.idx_ok) begin
                     cmd.ra   = RA_IDX;
                     state_in = S_RD_CHK;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               OP_REMOVE: begin
                  if (stat.idx_ok) begin
                     cmd.act  = ACT_SET_IDX;
                     state_in = S_RM_TEST;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               OP_FIND: begin
                  state_in = S_FD_TEST;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_LAST_CHK: begin
            cmd.act = ACT_LAST;
            if (stat.gt || stat.count_one) begin
               state_in = S_POS_DONE;
            end else begin
               state_in = S_MID_TEST;
            end
         end
         S_MID_TEST: begin
            if (stat.adjacent) begin
               cmd.ra   = RA_LO;
               state_in = S_LO_CHK;
            end else begin
               cmd.ra   = RA_MID;
               state_in = S_MID_CHK;
            end
         end
         S_MID_CHK: begin
            cmd.act  = ACT_MID;
            state_in = S_MID_TEST;
         end
         S_LO_CHK: begin
            cmd.act  = ACT_LO;
            state_in = S_POS_DONE;
         end
         S_POS_DONE: begin
            if (stat.op == OP_EXISTS) begin
               if (stat.pos_lt_count) begin
                  cmd.ra   = RA_POS;
                  state_in = S_EX_CHK;
               end else begin
                  state_in = S_FIN;
               end
            end else if (stat.full) begin
               state_in = S_FIN;
            end else begin
               cmd.act  = ACT_SH_SET;
               state_in = S_SH_TEST;
            end
         end
         S_EX_CHK: begin
            cmd.act  = ACT_EX_CHK;
            state_in = S_FIN;
         end
         S_SH_TEST: begin
            if (stat.ptr_gt_pos) begin
               cmd.ra   = RA_PTR_DN;
               state_in = S_SH_WR;
            end else begin
               cmd.wr   = WR_NEW;
               state_in = S_FIN;
            end
         end
         S_SH_WR: begin
            cmd.wr   = WR_SHIFT;
            cmd.act  = ACT_DEC;
            state_in = S_SH_TEST;
         end
         S_RM_TEST: begin
            if (stat.rm_more) begin
               cmd.ra   = RA_PTR_UP;
               state_in = S_RM_WR;
            end else begin
               state_in = S_FIN;
            end
         end
         S_RM_WR: begin
            cmd.wr   = WR_SHIFT;
            cmd.act  = ACT_INC;
            state_in = S_RM_TEST;
         end
         S_FD_TEST: begin
            if (stat.fd_more) begin
               cmd.ra   = RA_PTR;
               state_in = S_FD_CHK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FD_CHK: begin
            cmd.act  = ACT_H_CHK;
            state_in = stat.hmatch ? S_FIN : S_FD_TEST;
         end
         S_RD_CHK: begin
            cmd.act  = ACT_RD_OUT;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.act  = ACT_FIN;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == S_FIN);
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   `SKT_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy,
      "accepted request did not raise busy")
   `SKT_ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid,
      "response strobe longer than one cycle")
   `SKT_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_valid, !busy && state_ff == S_IDLE,
      "response strobe while busy")
endmodule
